// File: hw/rtl/mrra_pkg.sv
// Shared types, constants and rectangle helpers for the region allocator.
package mrra_pkg;

    localparam int MAX_FREE_RECTS = 64;
    localparam int MAX_PAGES      = 16;
    localparam int COORD_BITS     = 14;
    localparam int SIZE_BITS      = COORD_BITS + 1;
    localparam int FT_AW          = $clog2(MAX_FREE_RECTS);
    localparam int CNT_W          = FT_AW + 1;
    localparam int SC_DEPTH       = 4 * MAX_FREE_RECTS;
    localparam int SC_AW          = $clog2(SC_DEPTH);
    localparam int SC_CNT_W       = SC_AW + 1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NO_FIT  = 3'd1,
        ST_OUTSIDE = 3'd2,
        ST_OVERLAP = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    localparam logic CFG_ATLAS_W = 1'b0;
    localparam logic CFG_ATLAS_H = 1'b1;

    // coordinates carry one spare bit: split pieces can start past 2^COORD_BITS
    typedef struct packed {
        logic [3:0]           page;
        logic [SIZE_BITS-1:0] x;
        logic [SIZE_BITS-1:0] y;
        logic [SIZE_BITS-1:0] w;
        logic [SIZE_BITS-1:0] h;
    } rect_t;

    function automatic logic [SIZE_BITS:0] rend(input logic [SIZE_BITS-1:0] p,
                                                input logic [SIZE_BITS-1:0] s);
        rend = {1'b0, p} + {1'b0, s};
    endfunction

    function automatic logic overlap(input rect_t a, input rect_t b);
        overlap = (a.page == b.page) &&
                  ({1'b0, a.x} < rend(b.x, b.w)) && ({1'b0, b.x} < rend(a.x, a.w)) &&
                  ({1'b0, a.y} < rend(b.y, b.h)) && ({1'b0, b.y} < rend(a.y, a.h));
    endfunction

    function automatic logic contains(input rect_t outer, input rect_t inner);
        contains = (outer.page == inner.page) &&
                   (inner.x >= outer.x) && (inner.y >= outer.y) &&
                   (rend(inner.x, inner.w) <= rend(outer.x, outer.w)) &&
                   (rend(inner.y, inner.h) <= rend(outer.y, outer.h));
    endfunction

endpackage

// File: hw/rtl/maxrects_region_allocator.sv
// Top level: maxrects free-rectangle allocator with its sequencer and tables.
// Clear and unused codes go straight to the result; add checks the N free entries
// for overlap; allocate runs a fit scan, a split into P pieces in the scratch table,
// a pairwise prune over the scratch table and a copy back into the free table.
// One word at a time, paced by the single table read port: s_ready is high only in
// idle. Sync active-low reset empties the table at once (count cleared), sets both
// atlas registers to 4096; no clearing pass.
module maxrects_region_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [3:0]  s_page,
    input  logic [13:0] s_pos_x,
    input  logic [13:0] s_pos_y,
    input  logic [14:0] s_size_w,
    input  logic [14:0] s_size_h,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_out_page,
    output logic [13:0] m_out_x,
    output logic [13:0] m_out_y
);

    localparam int SB = mrra_pkg::SIZE_BITS;
    localparam int CB = mrra_pkg::COORD_BITS;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_ADD_RD   = 15'b000000000000010,
        S_ADD_CHK  = 15'b000000000000100,
        S_BEST_RD  = 15'b000000000001000,
        S_BEST_CHK = 15'b000000000010000,
        S_SPL_RD   = 15'b000000000100000,
        S_SPL_CHK  = 15'b000000001000000,
        S_SPL_PUSH = 15'b000000010000000,
        S_PR_RDI   = 15'b000000100000000,
        S_PR_LDI   = 15'b000001000000000,
        S_PR_RDJ   = 15'b000010000000000,
        S_PR_CHKJ  = 15'b000100000000000,
        S_CP_RD    = 15'b001000000000000,
        S_CP_WR    = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } state_t;

    // config
    logic [SB-1:0] atlas_w_reg, atlas_h_reg;

    // sequencer state
    state_t                          state_reg, state_next;
    mrra_pkg::rect_t                 req_reg, req_next;
    logic [mrra_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [mrra_pkg::SC_CNT_W-1:0]   idx_reg, idx_next;
    logic [mrra_pkg::SC_CNT_W-1:0]   j_reg, j_next;
    logic [mrra_pkg::SC_CNT_W-1:0]   n_reg, n_next;
    logic [mrra_pkg::SC_CNT_W-1:0]   kept_reg, kept_next;
    logic                            found_reg, found_next;
    logic [63:0]                     best_reg, best_next;
    mrra_pkg::rect_t                 used_reg, used_next;
    mrra_pkg::rect_t                 f_reg, f_next;
    mrra_pkg::rect_t                 cur_reg, cur_next;
    logic [4:0]                      pmask_reg, pmask_next;

    // pending result and output register
    logic [2:0]    res_status_reg, res_status_next;
    logic [3:0]    res_page_reg, res_page_next;
    logic [CB-1:0] res_x_reg, res_x_next;
    logic [CB-1:0] res_y_reg, res_y_next;
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [3:0]    m_page_reg, m_page_next;
    logic [CB-1:0] m_x_reg, m_x_next;
    logic [CB-1:0] m_y_reg, m_y_next;

    // free table and scratch table
    mrra_pkg::rect_t ft_mem [mrra_pkg::MAX_FREE_RECTS];
    mrra_pkg::rect_t ft_rdata;
    logic [mrra_pkg::FT_AW-1:0] ft_raddr, ft_waddr;
    logic            ft_we;
    mrra_pkg::rect_t ft_wdata;

    mrra_pkg::rect_t sc_mem [mrra_pkg::SC_DEPTH];
    mrra_pkg::rect_t sc_rdata;
    logic [mrra_pkg::SC_AW-1:0] sc_raddr, sc_waddr;
    logic            sc_we;
    mrra_pkg::rect_t sc_wdata;

    always_ff @(posedge aclk) begin
        if (ft_we) begin
            ft_mem[ft_waddr] <= ft_wdata;
        end
        ft_rdata <= ft_mem[ft_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sc_we) begin
            sc_mem[sc_waddr] <= sc_wdata;
        end
        sc_rdata <= sc_mem[sc_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atlas_w_reg <= SB'(4096);
            atlas_h_reg <= SB'(4096);
        end else if (cfg_we) begin
            if (cfg_index == mrra_pkg::CFG_ATLAS_W) begin
                atlas_w_reg <= cfg_wdata;
            end else begin
                atlas_h_reg <= cfg_wdata;
            end
        end
    end

    // Intake checks, done on the live word
    logic [SB:0] add_xe, add_ye;
    logic        add_bad;
    assign add_xe  = {2'b00, s_pos_x} + {1'b0, s_size_w};
    assign add_ye  = {2'b00, s_pos_y} + {1'b0, s_size_h};
    assign add_bad = (s_size_w == '0) || (s_size_h == '0) ||
                     ({1'b0, s_page} >= 5'(mrra_pkg::MAX_PAGES)) ||
                     (add_xe > {1'b0, atlas_w_reg}) || (add_ye > {1'b0, atlas_h_reg});

    // Fit score of the entry on the read port: short leftover, long leftover,
    // page, y, x.  Lower wins; ties keep the earlier entry.
    logic [SB-1:0] rx, ry;
    logic          fits;
    logic [63:0]   score;
    assign fits  = (req_reg.w <= ft_rdata.w) && (req_reg.h <= ft_rdata.h);
    assign rx    = ft_rdata.w - req_reg.w;
    assign ry    = ft_rdata.h - req_reg.h;
    assign score = (rx < ry) ? {rx, ry, ft_rdata.page, ft_rdata.y, ft_rdata.x}
                             : {ry, rx, ft_rdata.page, ft_rdata.y, ft_rdata.x};

    // Split pieces of f_reg around the placed rectangle
    logic [SB:0] ux_end, uy_end, fx_end, fy_end;
    mrra_pkg::rect_t piece;
    logic [4:0]      pmask_clr;
    assign ux_end = mrra_pkg::rend(used_reg.x, used_reg.w);
    assign uy_end = mrra_pkg::rend(used_reg.y, used_reg.h);
    assign fx_end = mrra_pkg::rend(f_reg.x, f_reg.w);
    assign fy_end = mrra_pkg::rend(f_reg.y, f_reg.h);

    always_comb begin
        piece     = f_reg;
        pmask_clr = pmask_reg;
        if (pmask_reg[4]) begin
            pmask_clr[4] = 1'b0;
        end else if (pmask_reg[0]) begin
            piece.w      = used_reg.x - f_reg.x;
            pmask_clr[0] = 1'b0;
        end else if (pmask_reg[1]) begin
            piece.x      = ux_end[SB-1:0];
            piece.w      = SB'(fx_end - ux_end);
            pmask_clr[1] = 1'b0;
        end else if (pmask_reg[2]) begin
            piece.h      = used_reg.y - f_reg.y;
            pmask_clr[2] = 1'b0;
        end else if (pmask_reg[3]) begin
            piece.y      = uy_end[SB-1:0];
            piece.h      = SB'(fy_end - uy_end);
            pmask_clr[3] = 1'b0;
        end
    end

    logic [SB:0] rd_xe, rd_ye;
    assign rd_xe = mrra_pkg::rend(ft_rdata.x, ft_rdata.w);
    assign rd_ye = mrra_pkg::rend(ft_rdata.y, ft_rdata.h);

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        kept_next       = kept_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        used_next       = used_reg;
        f_next          = f_reg;
        cur_next        = cur_reg;
        pmask_next      = pmask_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_page_next     = m_page_reg;
        m_x_next        = m_x_reg;
        m_y_next        = m_y_reg;

        ft_raddr = idx_reg[mrra_pkg::FT_AW-1:0];
        ft_we    = 1'b0;
        ft_waddr = cnt_reg[mrra_pkg::FT_AW-1:0];
        ft_wdata = req_reg;
        sc_raddr = idx_reg[mrra_pkg::SC_AW-1:0];
        sc_we    = 1'b0;
        sc_waddr = n_reg[mrra_pkg::SC_AW-1:0];
        sc_wdata = piece;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next.page   = s_page;
                    req_next.x      = {1'b0, s_pos_x};
                    req_next.y      = {1'b0, s_pos_y};
                    req_next.w      = s_size_w;
                    req_next.h      = s_size_h;
                    res_status_next = mrra_pkg::ST_OK;
                    res_page_next   = '0;
                    res_x_next      = '0;
                    res_y_next      = '0;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    state_next      = S_DONE;
                    unique case (mrra_pkg::cmd_t'(s_command))
                        mrra_pkg::CMD_CLEAR: cnt_next = '0;
                        mrra_pkg::CMD_ADD: begin
                            if (add_bad) begin
                                res_status_next = mrra_pkg::ST_OUTSIDE;
                            end else begin
                                state_next = S_ADD_RD;
                            end
                        end
                        mrra_pkg::CMD_ALLOC: begin
                            if (s_size_w == '0 || s_size_h == '0) begin
                                res_status_next = mrra_pkg::ST_NO_FIT;
                            end else begin
                                state_next = S_BEST_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD_RD: begin
                if (idx_reg == mrra_pkg::SC_CNT_W'(cnt_reg)) begin
                    state_next = S_DONE;
                    if (cnt_reg >= mrra_pkg::CNT_W'(mrra_pkg::MAX_FREE_RECTS)) begin
                        res_status_next = mrra_pkg::ST_FULL;
                    end else begin
                        ft_we    = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end else begin
                    state_next = S_ADD_CHK;
                end
            end
            S_ADD_CHK: begin
                if (mrra_pkg::overlap(ft_rdata, req_reg)) begin
                    res_status_next = mrra_pkg::ST_OVERLAP;
                    state_next      = S_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_ADD_RD;
                end
            end
            S_BEST_RD: begin
                if (idx_reg == mrra_pkg::SC_CNT_W'(cnt_reg)) begin
                    idx_next = '0;
                    n_next   = '0;
                    if (found_reg) begin
                        state_next = S_SPL_RD;
                    end else begin
                        res_status_next = mrra_pkg::ST_NO_FIT;
                        state_next      = S_DONE;
                    end
                end else begin
                    state_next = S_BEST_CHK;
                end
            end
            S_BEST_CHK: begin
                if (fits && (!found_reg || score < best_reg)) begin
                    found_next     = 1'b1;
                    best_next      = score;
                    used_next      = ft_rdata;
                    used_next.w    = req_reg.w;
                    used_next.h    = req_reg.h;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_BEST_RD;
            end
            S_SPL_RD: begin
                if (idx_reg == mrra_pkg::SC_CNT_W'(cnt_reg)) begin
                    idx_next   = '0;
                    kept_next  = '0;
                    state_next = S_PR_RDI;
                end else begin
                    state_next = S_SPL_CHK;
                end
            end
            S_SPL_CHK: begin
                f_next = ft_rdata;
                if (!mrra_pkg::overlap(ft_rdata, used_reg)) begin
                    pmask_next = 5'b10000;
                end else begin
                    pmask_next = {1'b0, uy_end < rd_ye, used_reg.y > ft_rdata.y,
                                  ux_end < rd_xe, used_reg.x > ft_rdata.x};
                end
                state_next = S_SPL_PUSH;
            end
            S_SPL_PUSH: begin
                if (pmask_reg == '0) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SPL_RD;
                end else begin
                    sc_we      = 1'b1;
                    n_next     = n_reg + 1'b1;
                    pmask_next = pmask_clr;
                end
            end
            // prune: entry i goes if empty or held inside any entry still present;
            // a pruned entry gets zero width in place, and an empty entry never
            // holds a non-empty one, so it drops out of later compares by itself
            S_PR_RDI: begin
                if (idx_reg == n_reg) begin
                    if (kept_reg > mrra_pkg::SC_CNT_W'(mrra_pkg::MAX_FREE_RECTS)) begin
                        res_status_next = mrra_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end else begin
                        idx_next   = '0;
                        j_next     = '0;
                        state_next = S_CP_RD;
                    end
                end else begin
                    state_next = S_PR_LDI;
                end
            end
            S_PR_LDI: begin
                cur_next = sc_rdata;
                j_next   = '0;
                if (sc_rdata.w == '0 || sc_rdata.h == '0) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PR_RDI;
                end else begin
                    state_next = S_PR_RDJ;
                end
            end
            S_PR_RDJ: begin
                sc_raddr = j_reg[mrra_pkg::SC_AW-1:0];
                if (j_reg == n_reg) begin
                    kept_next  = kept_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PR_RDI;
                end else if (j_reg == idx_reg) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    state_next = S_PR_CHKJ;
                end
            end
            S_PR_CHKJ: begin
                if (mrra_pkg::contains(sc_rdata, cur_reg)) begin
                    sc_we      = 1'b1;
                    sc_waddr   = idx_reg[mrra_pkg::SC_AW-1:0];
                    sc_wdata   = cur_reg;
                    sc_wdata.w = '0;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PR_RDI;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_PR_RDJ;
                end
            end
            S_CP_RD: begin
                if (idx_reg == n_reg) begin
                    cnt_next      = mrra_pkg::CNT_W'(j_reg);
                    res_page_next = used_reg.page;
                    res_x_next    = used_reg.x[CB-1:0];
                    res_y_next    = used_reg.y[CB-1:0];
                    state_next    = S_DONE;
                end else begin
                    state_next = S_CP_WR;
                end
            end
            S_CP_WR: begin
                if (sc_rdata.w != '0) begin
                    ft_we    = 1'b1;
                    ft_waddr = j_reg[mrra_pkg::FT_AW-1:0];
                    ft_wdata = sc_rdata;
                    j_next   = j_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_CP_RD;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_page_next   = res_page_reg;
                    m_x_next      = res_x_reg;
                    m_y_next      = res_y_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        j_reg          <= j_next;
        n_reg          <= n_next;
        kept_reg       <= kept_next;
        found_reg      <= found_next;
        best_reg       <= best_next;
        used_reg       <= used_next;
        f_reg          <= f_next;
        cur_reg        <= cur_next;
        pmask_reg      <= pmask_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        m_status_reg   <= m_status_next;
        m_page_reg     <= m_page_next;
        m_x_reg        <= m_x_next;
        m_y_reg        <= m_y_next;
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_out_page = m_page_reg;
    assign m_out_x    = m_x_reg;
    assign m_out_y    = m_y_reg;

    // table never holds more than its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= mrra_pkg::CNT_W'(mrra_pkg::MAX_FREE_RECTS))
        else $error("free count beyond table depth");

    // an accepted word leaves the block busy in the cycle after it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready while a word is in work");

    // copy-back never writes past the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CP_WR && sc_rdata.w != '0 |->
            j_reg < mrra_pkg::SC_CNT_W'(mrra_pkg::MAX_FREE_RECTS))
        else $error("copy-back past table end");

endmodule
